FILE: src/itf_pkg.sv
// Shared constants and types for the instruction trap filter.
package itf_pkg;

	localparam int SYS_ENTRIES = 1024;
	localparam int BASE_ENTRIES = 256;
	localparam int SYS_AW = $clog2(SYS_ENTRIES);
	localparam int BASE_AW = $clog2(BASE_ENTRIES);

	localparam logic [9:0] PRIV_TOP = 10'd852;
	localparam logic [10:0] BRK_OPC = 11'b11010100001;
	localparam logic [12:0] TRAP_MARK = 13'b1000000000000;
	localparam logic [12:0] FILTER_IMM = 13'b1111111111111;
	localparam logic [31:0] HIGH_MASK = 32'b11111111111000000000000000000000;

	localparam logic [1:0] ACT_SCAN = 2'd0;
	localparam logic [1:0] ACT_WR_SYS = 2'd1;
	localparam logic [1:0] ACT_WR_BASE = 2'd2;

	localparam logic [1:0] V_PASS = 2'd0;
	localparam logic [1:0] V_TRAP = 2'd1;
	localparam logic [1:0] V_FILTER = 2'd2;

	typedef logic [31:0] word_t;
	typedef logic [SYS_AW-1:0] sys_addr_t;
	typedef logic [BASE_AW-1:0] base_addr_t;

	function automatic word_t brk_word(input logic [12:0] imm);
		brk_word = {BRK_OPC, 3'b000, imm, 5'b00000};
	endfunction

endpackage

FILE: src/instruction_trap_filter_core.sv
// Instruction trap filter: rule tables in synchronous memories and the classify pipeline.
// A scan is registered in the read stage, then the output register; a stall holds both.
// Throughput: one item per cycle unless stalled or clearing; each scan reads both tables.
// Table writes produce no result and finish at the accepting edge.
// After reset a pass over the 1024 system entries clears both tables, one entry per cycle,
// during which s_tready stays low.
module instruction_trap_filter_core
	import itf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: instruction[31:0], table_index[41:32], entry_value[105:42], zero pad.
	input  logic [111:0] s_tdata,
	// Fields from bit 0: action[1:0].
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: verdict[1:0], replacement[33:2], zero pad.
	output logic [39:0]  m_tdata,
	// Fields from bit 0: privileged[0].
	output logic         m_tuser
);

	logic [31:0] sys_mem [SYS_ENTRIES];
	logic [63:0] base_mem [BASE_ENTRIES];

	logic        clearing_q;
	sys_addr_t   clr_cnt_q;

	logic        valid_s1;
	word_t       instr_s1;
	logic        priv_s1;
	logic        neg_s1;
	logic [31:0] sys_rd_q;
	logic [63:0] base_rd_q;

	logic        out_valid_q;
	logic [1:0]  out_verdict_q;
	word_t       out_repl_q;
	logic        out_priv_q;

	logic        en;
	logic        accept;
	logic [1:0]  act;
	word_t       instr;
	logic [9:0]  tbl_idx;
	logic [63:0] ent_val;
	logic        priv;
	logic [SYS_AW:0] hash;
	base_addr_t  slot;
	logic        sys_we;
	logic        base_we;
	sys_addr_t   sys_waddr;
	base_addr_t  base_waddr;
	logic [31:0] sys_wdata;
	logic [63:0] base_wdata;
	logic        sys_hit;
	logic        base_hit;
	word_t       base_mask;
	logic [1:0]  verdict;
	word_t       repl;

	assign act = s_tuser;
	assign instr = s_tdata[31:0];
	assign tbl_idx = s_tdata[41:32];
	assign ent_val = s_tdata[105:42];

	assign en = !out_valid_q || m_tready;
	assign s_tready = en && !clearing_q;
	assign accept = s_tvalid && s_tready;

	assign priv = (instr[31:22] == PRIV_TOP) && ((instr[20:19] == 2'b01) || instr[20]);
	assign hash = {1'b0, instr[21:12]} - {4'b0000, instr[11:5]};
	assign slot = {instr[25:24], instr[13], instr[7:5], instr[1:0]};

	assign sys_we = clearing_q || (accept && act == ACT_WR_SYS);
	assign base_we = clearing_q || (accept && act == ACT_WR_BASE);
	assign sys_waddr = clearing_q ? clr_cnt_q : tbl_idx[SYS_AW-1:0];
	assign base_waddr = clearing_q ? clr_cnt_q[BASE_AW-1:0] : tbl_idx[BASE_AW-1:0];
	assign sys_wdata = clearing_q ? 32'd0 : ent_val[31:0];
	assign base_wdata = clearing_q ? 64'd0 : ent_val;

	always_ff @(posedge clk) begin
		if (sys_we) begin
			sys_mem[sys_waddr] <= sys_wdata;
		end
		if (en) begin
			sys_rd_q <= sys_mem[hash[SYS_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem[base_waddr] <= base_wdata;
		end
		if (en) begin
			base_rd_q <= base_mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == sys_addr_t'(SYS_ENTRIES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && act == ACT_SCAN;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			instr_s1 <= instr;
			priv_s1 <= priv;
			neg_s1 <= hash[SYS_AW];
			out_verdict_q <= verdict;
			out_repl_q <= repl;
			out_priv_q <= priv_s1;
		end
	end

	assign sys_hit = !neg_s1 && (sys_rd_q != 32'd0)
		&& ({4'd0, instr_s1[31:5]} == sys_rd_q[31:1]);
	assign base_mask = {1'b0, base_rd_q[63:33]} | HIGH_MASK;
	assign base_hit = (base_rd_q != 64'd0) && ((instr_s1 & base_mask) == base_rd_q[32:1]);

	always_comb begin
		verdict = V_PASS;
		repl = '0;
		if (priv_s1) begin
			if (!sys_hit) begin
				verdict = V_FILTER;
				repl = brk_word(FILTER_IMM);
			end else if (sys_rd_q[0]) begin
				verdict = V_TRAP;
				repl = brk_word(TRAP_MARK | {1'b0, instr_s1[11:0]});
			end
		end else if (base_hit) begin
			if (base_rd_q[0]) begin
				verdict = V_TRAP;
				repl = brk_word(TRAP_MARK | {1'b0, instr_s1[11:0]});
			end else begin
				verdict = V_FILTER;
				repl = brk_word(FILTER_IMM);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_repl_q, out_verdict_q};
	assign m_tuser = out_priv_q;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s_tready)
		else $error("Input accepted during the table clearing pass.");

	a_scan_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == ACT_SCAN) |=> valid_s1)
		else $error("Accepted scan did not reach the read stage.");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser != ACT_SCAN) |=> !valid_s1)
		else $error("A table write or unused action produced a result.");

	a_pass_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_verdict_q == V_PASS) |-> (out_repl_q == 32'd0))
		else $error("Pass verdict carries a nonzero replacement word.");

endmodule

FILE: dv/trap_filter_checker.sv
// Checker for the instruction trap filter: mirrors both rule tables and compares every verdict.
module trap_filter_checker
	import itf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic         m_tuser,
	output int           mismatches,
	output int           outstanding
);

	typedef struct packed {
		logic [1:0] verdict;
		word_t      replacement;
		logic       privileged;
	} verdict_t;

	word_t       sys_rules [SYS_ENTRIES];
	logic [63:0] base_rules [BASE_ENTRIES];
	verdict_t    verdicts_due [$];
	int          error_total;

	function automatic word_t trap_brk(input word_t w);
		return {BRK_OPC, 21'd0} + ({19'd0, TRAP_MARK | {1'b0, w[11:0]}} << 5);
	endfunction

	function automatic word_t filter_brk();
		return {BRK_OPC, 21'd0} + ({19'd0, FILTER_IMM} << 5);
	endfunction

	function automatic verdict_t classify(input word_t w);
		verdict_t    r;
		logic [9:0]  hi;
		logic [6:0]  lo;
		word_t       se;
		logic [63:0] be;
		word_t       mask;
		r.verdict = V_PASS;
		r.replacement = 32'd0;
		r.privileged = (w[31:22] == PRIV_TOP) && ((w[20:19] == 2'b01) || w[20]);
		if (r.privileged) begin
			hi = w[21:12];
			lo = w[11:5];
			se = 32'd0;
			if (hi >= {3'd0, lo}) begin
				se = sys_rules[hi - {3'd0, lo}];
			end
			if ((se != 32'd0) && ({4'd0, w[31:5]} == se[31:1])) begin
				if (se[0]) begin
					r.verdict = V_TRAP;
					r.replacement = trap_brk(w);
				end
			end else begin
				r.verdict = V_FILTER;
				r.replacement = filter_brk();
			end
		end else begin
			be = base_rules[{w[25:24], w[13], w[7:5], w[1:0]}];
			if (be != 64'd0) begin
				mask = {1'b0, be[63:33]} | HIGH_MASK;
				if ((w & mask) == be[32:1]) begin
					if (be[0]) begin
						r.verdict = V_TRAP;
						r.replacement = trap_brk(w);
					end else begin
						r.verdict = V_FILTER;
						r.replacement = filter_brk();
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t due;
		verdict_t seen;
		if (!arst_n) begin
			for (int i = 0; i < SYS_ENTRIES; i++) sys_rules[i] = 32'd0;
			for (int i = 0; i < BASE_ENTRIES; i++) base_rules[i] = 64'd0;
			verdicts_due.delete();
			error_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.verdict = m_tdata[1:0];
				seen.replacement = m_tdata[33:2];
				seen.privileged = m_tuser;
				if (verdicts_due.size() == 0) begin
					error_total++;
					if (error_total <= 10) begin
						$display("Result transfer with no scan pending: verdict %0d replacement %h privileged %0d",
							seen.verdict, seen.replacement, seen.privileged);
					end
				end else begin
					due = verdicts_due.pop_front();
					if (seen != due) begin
						error_total++;
						if (error_total <= 10) begin
							$display("Mismatch: expected verdict %0d replacement %h privileged %0d, got verdict %0d replacement %h privileged %0d",
								due.verdict, due.replacement, due.privileged,
								seen.verdict, seen.replacement, seen.privileged);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					ACT_SCAN: begin
						verdicts_due.push_back(classify(s_tdata[31:0]));
					end
					ACT_WR_SYS: begin
						sys_rules[s_tdata[41:32]] = s_tdata[73:42];
					end
					ACT_WR_BASE: begin
						base_rules[s_tdata[39:32]] = s_tdata[105:42];
					end
					default: begin
					end
				endcase
			end
			mismatches <= error_total;
			outstanding <= verdicts_due.size();
		end
	end

endmodule

FILE: dv/instruction_trap_filter_core_tb.sv
// Testbench top for the instruction trap filter: drives table writes and scans, gives the verdict.
module instruction_trap_filter_core_tb;
	import itf_pkg::*;

	localparam int RANDOM_ITEMS = 1130;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] ACT_NONE = 2'd3;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = ACT_SCAN;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	logic         m_tuser;
	int           mismatches;
	int           outstanding;
	int           cycles = 0;
	int           items_sent = 0;
	bit           quiet = 1'b0;

	instruction_trap_filter_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	trap_filter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic word_t rand_priv_word();
		word_t w;
		w = $urandom;
		w[31:22] = PRIV_TOP;
		if (w[20:19] == 2'b00) begin
			w[19 + $urandom_range(0, 1)] = 1'b1;
		end
		return w;
	endfunction

	function automatic word_t rand_plain_word();
		word_t w;
		w = $urandom;
		if (w[31:22] == PRIV_TOP) begin
			w[22] = ~w[22];
		end
		return w;
	endfunction

	function automatic logic [7:0] base_slot_of(input word_t w);
		return {w[25:24], w[13], w[7:5], w[1:0]};
	endfunction

	function automatic logic [63:0] base_rule_for(input word_t w, input logic flag);
		logic [30:0] m;
		m = $urandom;
		return {m, w & ({1'b0, m} | HIGH_MASK), flag};
	endfunction

	function automatic logic [63:0] sys_rule_for(input word_t w, input logic flag);
		logic [31:0] upper;
		logic [3:0]  top;
		upper = $urandom;
		top = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd0;
		return {upper, top, w[31:5], flag};
	endfunction

	task automatic push_item(input logic [1:0] act, input word_t instr, input logic [9:0] idx,
			input logic [63:0] val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'd0, val, idx, instr};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		word_t      w;
		word_t      v;
		logic [9:0] hash;
		int         next_drain;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(ACT_SCAN, 32'h0000_0000, 10'd0, 64'd0);
		push_item(ACT_SCAN, 32'hFFFF_FFFF, 10'h3FF, {64{1'b1}});
		// System hash of one: bits[21:12] at 128, bits[11:5] at 127.
		w = {PRIV_TOP, 10'd128, 7'd127, 5'd0};
		push_item(ACT_SCAN, w, 10'd0, 64'd0);
		push_item(ACT_WR_SYS, 32'd0, 10'd1, {32'd0, 4'd0, w[31:5], 1'b1});
		push_item(ACT_SCAN, w, 10'd0, 64'd0);
		// Largest system hash with a pass rule.
		w = {PRIV_TOP, 10'h3FF, 7'd0, 5'h1F};
		push_item(ACT_WR_SYS, 32'd0, 10'h3FF, {32'hFFFF_FFFF, 4'd0, w[31:5], 1'b0});
		push_item(ACT_SCAN, w, 10'd0, 64'd0);
		push_item(ACT_SCAN, {PRIV_TOP, 10'h3FF, 7'd1, 5'h1F}, 10'd0, 64'd0);
		push_item(ACT_WR_SYS, 32'hFFFF_FFFF, 10'd0, {64{1'b1}});
		push_item(ACT_SCAN, {PRIV_TOP, 10'b0110000000, 7'd0, 5'd0}, 10'd0, 64'd0);
		push_item(ACT_SCAN, {PRIV_TOP, 10'b0100000000, 7'd0, 5'd0}, 10'd0, 64'd0);
		// Base table index above 255 folds onto the low 8 bits.
		push_item(ACT_WR_BASE, 32'd0, 10'h3FF, {64{1'b1}});
		push_item(ACT_SCAN, 32'hFFFF_FFFF, 10'd0, 64'd0);
		push_item(ACT_WR_BASE, 32'd0, 10'h0FF, 64'hFFFF_FFFF_FFFF_FFFE);
		push_item(ACT_SCAN, 32'hFFFF_FFFF, 10'd0, 64'd0);
		push_item(ACT_WR_BASE, 32'd0, 10'd0, 64'd1);
		push_item(ACT_SCAN, 32'h0000_0000, 10'd0, 64'd0);
		push_item(ACT_SCAN, 32'h001F_DF1C, 10'd0, 64'd0);
		push_item(ACT_SCAN, 32'h0020_0000, 10'd0, 64'd0);
		push_item(ACT_NONE, 32'hFFFF_FFFF, 10'h3FF, {64{1'b1}});
		push_item(ACT_SCAN, 32'h0000_0000, 10'd0, 64'd0);
		push_item(ACT_WR_BASE, 32'd0, 10'd0, 64'd0);
		push_item(ACT_SCAN, 32'h0000_0000, 10'd0, 64'd0);
		drain();

		items_sent = 0;
		next_drain = 200;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) quiet = !quiet;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					w = rand_priv_word();
					hash = w[21:12] - {3'd0, w[11:5]};
					push_item(ACT_WR_SYS, $urandom, hash, sys_rule_for(w, 1'($urandom)));
					push_item(ACT_SCAN, {w[31:5], 5'($urandom)}, 10'($urandom),
						{$urandom, $urandom});
					v = w ^ (32'd1 << $urandom_range(5, 31));
					push_item(ACT_SCAN, v, 10'($urandom), {$urandom, $urandom});
				end
				3, 4, 5: begin
					w = rand_plain_word();
					push_item(ACT_WR_BASE, $urandom, {2'($urandom), base_slot_of(w)},
						base_rule_for(w, 1'($urandom)));
					push_item(ACT_SCAN, w, 10'($urandom), {$urandom, $urandom});
					v = w ^ (32'd1 << $urandom_range(0, 31));
					push_item(ACT_SCAN, v, 10'($urandom), {$urandom, $urandom});
				end
				6: begin
					push_item(($urandom_range(0, 1) == 0) ? ACT_WR_SYS : ACT_WR_BASE, $urandom,
						10'($urandom), {$urandom, $urandom});
				end
				7: begin
					push_item(ACT_SCAN, $urandom, 10'($urandom), {$urandom, $urandom});
				end
				8: begin
					push_item(ACT_SCAN, rand_priv_word(), 10'($urandom), {$urandom, $urandom});
				end
				default: begin
					push_item(ACT_NONE, $urandom, 10'($urandom), {$urandom, $urandom});
				end
			endcase
			if (items_sent >= next_drain) begin
				drain();
				next_drain = items_sent + 200;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
src/itf_pkg.sv
src/instruction_trap_filter_core.sv
dv/trap_filter_checker.sv
dv/instruction_trap_filter_core_tb.sv
